@@ design/modular_poly_from_roots_defines.svh @@
// Assertion macros used by the polynomial-from-roots top level
`ifndef MODULAR_POLY_FROM_ROOTS_DEFINES_SVH
`define MODULAR_POLY_FROM_ROOTS_DEFINES_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication, disabled while reset is high
`define MPFR_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("mpfr: same-cycle check failed");
// Next-cycle implication, disabled while reset is high
`define MPFR_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("mpfr: next-cycle check failed");
`else
`define MPFR_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define MPFR_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

@@ design/mpfr_pkg.sv @@
// Types and constants of the modular polynomial-from-roots block
package mpfr_pkg;

   localparam int COEFF_W    = 63;
   localparam int ROOT_W     = 64;
   localparam int DEG_W      = 4;
   localparam int RC_W       = 4;
   localparam int STEPS      = 64;
   localparam int STEP_CNT_W = $clog2(STEPS);

   localparam logic [COEFF_W-1:0] COEFF_ONE     = COEFF_W'(1);
   localparam logic [COEFF_W-1:0] MODULUS_RESET = COEFF_W'(65537);
   localparam logic [RC_W-1:0]    ROOT_CNT_RESET = RC_W'(3);

   typedef logic [0:0] csr_index_type;
   localparam csr_index_type CSR_MODULUS    = 1'b0;
   localparam csr_index_type CSR_ROOT_COUNT = 1'b1;

   typedef struct packed {
      logic [ROOT_W-1:0] root;
   } req_payload_type;

   typedef struct packed {
      logic [COEFF_W-1:0] coefficient;
      logic [DEG_W-1:0]   degree;
      logic               last;
   } rsp_payload_type;

   // Status returned by the bit-serial arithmetic units
   typedef struct packed {
      logic               done;
      logic [COEFF_W-1:0] result;
   } unit_sts_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ROOT,
      ST_FETCH,
      ST_START,
      ST_RUN,
      ST_STORE,
      ST_EMIT_RD,
      ST_EMIT_LD
   } state_type;

endpackage

@@ design/mpfr_stream_if.sv @@
// Valid/ready stream channel carrying one payload per transaction
interface mpfr_stream_if #(parameter type payload_type = logic);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

@@ design/mpfr_reduce.sv @@
// Bit-serial reduction of a 64-bit value modulo the configured modulus
module mpfr_reduce (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic [mpfr_pkg::ROOT_W-1:0]     x,
   input  logic [mpfr_pkg::COEFF_W-1:0]    modulus,
   output mpfr_pkg::unit_sts_type          sts
);
   import mpfr_pkg::*;

   logic [ROOT_W-1:0]     x_ff;
   logic [COEFF_W-1:0]    rem_ff;
   logic [COEFF_W-1:0]    rem_in;
   logic [STEP_CNT_W-1:0] cnt_ff;
   logic                  busy_ff;
   logic                  done_ff;
   logic [ROOT_W-1:0]     shifted;
   logic [ROOT_W-1:0]     trial;

   // Bring in the next bit, most significant first, and subtract once
   assign shifted = {rem_ff, x_ff[ROOT_W-1]};
   assign trial   = shifted - {1'b0, modulus};
   assign rem_in  = (shifted >= {1'b0, modulus}) ? trial[COEFF_W-1:0]
                                                 : shifted[COEFF_W-1:0];

   // Step counter and completion pulse
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == STEP_CNT_W'(STEPS - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // Operand shifter and partial remainder
   always_ff @(posedge clock) begin
      if (start) begin
         x_ff   <= x;
         rem_ff <= '0;
      end else if (busy_ff) begin
         x_ff   <= x_ff << 1;
         rem_ff <= rem_in;
      end
   end

   // A zero modulus reduces everything to zero
   assign sts.done   = done_ff;
   assign sts.result = (modulus == '0) ? '0 : rem_ff;

endmodule

@@ design/mpfr_mulmod.sv @@
// Interleaved double-and-add modular multiplier, one multiplier bit per cycle
module mpfr_mulmod (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic [mpfr_pkg::COEFF_W-1:0]    a,
   input  logic [mpfr_pkg::COEFF_W-1:0]    b,
   input  logic [mpfr_pkg::COEFF_W-1:0]    modulus,
   output mpfr_pkg::unit_sts_type          sts
);
   import mpfr_pkg::*;

   logic [COEFF_W-1:0]    a_ff;
   logic [COEFF_W-1:0]    b_ff;
   logic [COEFF_W-1:0]    acc_ff;
   logic [STEP_CNT_W-1:0] cnt_ff;
   logic                  busy_ff;
   logic                  done_ff;
   logic [COEFF_W:0]      mod_ext;
   logic [COEFF_W:0]      acc_sum;
   logic [COEFF_W:0]      acc_trial;
   logic [COEFF_W:0]      dbl_sum;
   logic [COEFF_W:0]      dbl_trial;
   logic [COEFF_W-1:0]    acc_in;
   logic [COEFF_W-1:0]    a_in;

   // Both operands stay below the modulus, so one subtract corrects each sum
   assign mod_ext   = {1'b0, modulus};
   assign acc_sum   = {1'b0, acc_ff} + {1'b0, a_ff};
   assign acc_trial = acc_sum - mod_ext;
   assign dbl_sum   = {a_ff, 1'b0};
   assign dbl_trial = dbl_sum - mod_ext;
   assign acc_in    = !b_ff[0] ? acc_ff :
                      (acc_sum >= mod_ext) ? acc_trial[COEFF_W-1:0] : acc_sum[COEFF_W-1:0];
   assign a_in      = (dbl_sum >= mod_ext) ? dbl_trial[COEFF_W-1:0] : dbl_sum[COEFF_W-1:0];

   // Step counter and completion pulse
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == STEP_CNT_W'(STEPS - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // Accumulate, double the multiplicand, walk the multiplier from its low bit
   always_ff @(posedge clock) begin
      if (start) begin
         a_ff   <= a;
         b_ff   <= b;
         acc_ff <= '0;
      end else if (busy_ff) begin
         a_ff   <= a_in;
         b_ff   <= b_ff >> 1;
         acc_ff <= acc_in;
      end
   end

   assign sts.done   = done_ff;
   assign sts.result = (modulus == '0) ? '0 : acc_ff;

endmodule

@@ design/modular_poly_from_roots.sv @@
// Top level: coefficient memory, fold sequencer and coefficient emission
// Each accepted root is reduced modulo the modulus, negated and folded into the
// coefficient vector kept in a synchronous memory with one write and one read
// port, one coefficient at a time from the highest degree down. A shared
// bit-serial reducer and a bit-serial modular multiplier, 64 steps each, run
// side by side per coefficient. Once the polynomial holds root_count roots
// (zero acts as one, values above MAX_ROOTS act as MAX_ROOTS), its k + 2
// coefficients, k being the roots held before the last one, leave lowest degree
// first, each read and then loaded into the result register, waiting while it
// is still full and the sink is not ready, with last set on the highest one; the
// vector returns to the constant one at once. The result register lets a new
// root be taken while the final coefficient still waits. Configuration is to be
// written only while idle, by the user; the block itself does not enforce it.
`include "modular_poly_from_roots_defines.svh"
module modular_poly_from_roots #(
   parameter int MAX_ROOTS = 8
) (
   input  logic                            clock,
   input  logic                            reset,
   mpfr_stream_if.sink                     req_ch,
   mpfr_stream_if.source                   rsp_ch,
   input  logic                            csr_we,
   input  mpfr_pkg::csr_index_type         csr_index,
   input  logic [mpfr_pkg::COEFF_W-1:0]    csr_wdata
);
   import mpfr_pkg::*;

   localparam int Depth = MAX_ROOTS + 1;
   localparam int AddrW = $clog2(Depth);
   localparam int CmpW  = (AddrW > RC_W) ? AddrW : RC_W;

   // Configuration
   logic [COEFF_W-1:0] modulus_ff;
   logic [RC_W-1:0]    root_count_ff;

   // Sequencer
   state_type          state_ff;
   state_type          state_in;
   logic               req_ready;
   logic               red_start;
   logic               mul_start;
   logic               mem_we;
   logic               out_load;
   logic [AddrW-1:0]   roots_taken_ff;
   logic [AddrW-1:0]   p_ff;
   logic [AddrW-1:0]   top_ff;
   logic [AddrW-1:0]   ep_ff;
   logic [AddrW-1:0]   n_sel;
   logic [CmpW-1:0]    rc_ext;
   logic [CmpW-1:0]    d_eff;
   logic               emit_now;
   logic               emit_last;

   // Datapath
   logic [COEFF_W-1:0] neg_ff;
   logic [COEFF_W-1:0] upper_ff;
   logic [ROOT_W-1:0]  red_x;
   unit_sts_type       red_sts;
   unit_sts_type       mul_sts;
   logic [COEFF_W:0]   sum;
   logic [COEFF_W:0]   sum_trial;
   logic [COEFF_W-1:0] mem_wdata;

   // Coefficient memory and its entry-valid flags
   logic [COEFF_W-1:0] coeff_mem [Depth];
   logic [Depth-1:0]   valid_ff;
   logic [AddrW-1:0]   rd_addr;
   logic [COEFF_W-1:0] mem_rd_ff;
   logic               rd_hit_ff;
   logic               rd_zero_ff;
   logic [COEFF_W-1:0] rd_val;

   // Output register
   logic               rsp_valid_ff;
   rsp_payload_type    rsp_pl_ff;

   // Arithmetic units
   mpfr_reduce u_reduce (
      .clock   (clock),
      .reset   (reset),
      .start   (red_start),
      .x       (red_x),
      .modulus (modulus_ff),
      .sts     (red_sts)
   );

   mpfr_mulmod u_mulmod (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .a       (upper_ff),
      .b       (neg_ff),
      .modulus (modulus_ff),
      .sts     (mul_sts)
   );

   // Effective degree and position bookkeeping
   assign n_sel     = (roots_taken_ff >= AddrW'(MAX_ROOTS - 1)) ? AddrW'(MAX_ROOTS - 1)
                                                                : roots_taken_ff;
   assign rc_ext    = CmpW'(root_count_ff);
   assign d_eff     = (root_count_ff == '0) ? CmpW'(1) :
                      (rc_ext > CmpW'(MAX_ROOTS)) ? CmpW'(MAX_ROOTS) : rc_ext;
   assign emit_now  = CmpW'(top_ff) >= d_eff;
   assign emit_last = (ep_ff == top_ff);

   // Reducer takes the root on acceptance, the stored coefficient below p later
   assign red_x = (state_ff != ST_START) ? req_ch.payload.root :
                  (p_ff == '0) ? '0 : {1'b0, rd_val};

   // New coefficient: product plus the reduced lower neighbour, one correction
   assign sum       = {1'b0, mul_sts.result} + {1'b0, red_sts.result};
   assign sum_trial = sum - {1'b0, modulus_ff};
   assign mem_wdata = (sum >= {1'b0, modulus_ff}) ? sum_trial[COEFF_W-1:0]
                                                  : sum[COEFF_W-1:0];

   // Read address: emission index while emitting, coefficient below p while folding
   assign rd_addr = (state_ff == ST_EMIT_RD || state_ff == ST_EMIT_LD) ? ep_ff :
                    (p_ff == '0) ? '0 : AddrW'(p_ff - 1'b1);

   // Entries never written since the last clear read as zero, entry zero as the constant one
   assign rd_val = rd_hit_ff ? mem_rd_ff : (rd_zero_ff ? COEFF_ONE : '0);

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and sequencer strobes
   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      red_start = 1'b0;
      mul_start = 1'b0;
      mem_we    = 1'b0;
      out_load  = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_ch.valid) begin
               red_start = 1'b1;
               state_in  = ST_ROOT;
            end
         end
         ST_ROOT: begin
            if (red_sts.done) state_in = ST_FETCH;
         end
         ST_FETCH: begin
            state_in = ST_START;
         end
         ST_START: begin
            red_start = 1'b1;
            mul_start = 1'b1;
            state_in  = ST_RUN;
         end
         ST_RUN: begin
            if (mul_sts.done) state_in = ST_STORE;
         end
         ST_STORE: begin
            mem_we = 1'b1;
            if (p_ff != '0) begin
               state_in = ST_FETCH;
            end else if (emit_now) begin
               state_in = ST_EMIT_RD;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_EMIT_RD: begin
            state_in = ST_EMIT_LD;
         end
         ST_EMIT_LD: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               out_load = 1'b1;
               state_in = emit_last ? ST_IDLE : ST_EMIT_RD;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign req_ch.ready = req_ready;

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         modulus_ff    <= MODULUS_RESET;
         root_count_ff <= ROOT_CNT_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_MODULUS:    modulus_ff    <= csr_wdata;
            CSR_ROOT_COUNT: root_count_ff <= csr_wdata[RC_W-1:0];
            default: ;
         endcase
      end
   end

   // Fold and emission counters, valid flags, result handshake
   always_ff @(posedge clock) begin
      if (reset) begin
         roots_taken_ff <= '0;
         p_ff           <= '0;
         top_ff         <= '0;
         ep_ff          <= '0;
         valid_ff       <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (req_ready && req_ch.valid) begin
            p_ff   <= AddrW'(n_sel + 1'b1);
            top_ff <= AddrW'(n_sel + 1'b1);
         end
         if (mem_we) begin
            valid_ff[p_ff] <= 1'b1;
            if (p_ff != '0) begin
               p_ff <= AddrW'(p_ff - 1'b1);
            end else begin
               roots_taken_ff <= top_ff;
               ep_ff          <= '0;
            end
         end
         if (out_load) begin
            if (emit_last) begin
               valid_ff       <= '0;
               roots_taken_ff <= '0;
            end else begin
               ep_ff <= AddrW'(ep_ff + 1'b1);
            end
         end
         if (out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Negated root, upper operand and result payload
   always_ff @(posedge clock) begin
      if (state_ff == ST_ROOT && red_sts.done) begin
         neg_ff <= (red_sts.result == '0) ? '0 : modulus_ff - red_sts.result;
      end
      if (req_ready && req_ch.valid) begin
         upper_ff <= '0;
      end else if (mem_we) begin
         upper_ff <= red_sts.result;
      end
      if (out_load) begin
         rsp_pl_ff.coefficient <= rd_val;
         rsp_pl_ff.degree      <= DEG_W'(ep_ff);
         rsp_pl_ff.last        <= emit_last;
      end
   end

   // Coefficient memory: one write, one registered read per cycle
   always_ff @(posedge clock) begin
      if (mem_we) begin
         coeff_mem[p_ff] <= mem_wdata;
      end
      mem_rd_ff  <= coeff_mem[rd_addr];
      rd_hit_ff  <= valid_ff[rd_addr];
      rd_zero_ff <= (rd_addr == '0);
   end

   assign rsp_ch.valid   = rsp_valid_ff;
   assign rsp_ch.payload = rsp_pl_ff;

   // Checks
   `MPFR_ASSERT_IMP(a_units_aligned, clock, reset, state_ff == ST_RUN, red_sts.done == mul_sts.done)
   `MPFR_ASSERT_IMP(a_write_in_range, clock, reset, mem_we, p_ff <= top_ff)
   `MPFR_ASSERT_NEXT(a_clear_after_emit, clock, reset, out_load && emit_last, roots_taken_ff == '0 && valid_ff == '0)

endmodule

@@ sim/modular_poly_from_roots_tb.sv @@
// Testbench for modular_poly_from_roots: streams roots and checks every emitted coefficient
`timescale 1ns / 100ps

module modular_poly_from_roots_tb;
   import mpfr_pkg::*;

   localparam int MAX_ROOTS = 8;
   localparam int RANDOM_ROOTS = 410;
   // covers the longest fold, with seven roots held
   localparam int SETTLE_CYCLES = 800;
   localparam int LIMIT_CYCLES = 2000000;
   localparam logic [COEFF_W-1:0] MODULUS_MAX = '1;

   typedef enum logic [1:0] {
      STALL_NONE,
      STALL_COIN,
      STALL_QUARTER,
      STALL_LONG
   } stall_mode_type;

   logic                   clock;
   logic                   reset;
   logic                   csr_we;
   csr_index_type          csr_index;
   logic [COEFF_W-1:0]     csr_wdata;
   int unsigned            burst_left;
   int unsigned            cycle_count;

   mpfr_stream_if #(.payload_type(req_payload_type)) req_ch ();
   mpfr_stream_if #(.payload_type(rsp_payload_type)) rsp_ch ();

   modular_poly_from_roots #(
      .MAX_ROOTS(MAX_ROOTS)
   ) u_top (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // Coefficient vector mirror: folds each accepted root and queues the emitted coefficients
   class coeff_tracker;
      logic [COEFF_W-1:0] modulus;
      logic [RC_W-1:0]    root_count;
      logic [COEFF_W-1:0] coeffs [0:MAX_ROOTS];
      int unsigned        roots_held;
      rsp_payload_type    pending_coeffs [$];
      int unsigned        failures;

      function new();
         modulus = MODULUS_RESET;
         root_count = ROOT_CNT_RESET;
         failures = 0;
         clear_poly();
      endfunction

      // Return the vector to the constant one
      function void clear_poly();
         foreach (coeffs[i]) coeffs[i] = '0;
         coeffs[0] = COEFF_ONE;
         roots_held = 0;
      endfunction

      function void write_reg(csr_index_type idx, logic [COEFF_W-1:0] value);
         if (idx == CSR_MODULUS) modulus = value;
         else root_count = value[RC_W-1:0];
      endfunction

      function bit [63:0] reduce(bit [63:0] x, bit [63:0] m);
         if (m == 0) return 0;
         return x % m;
      endfunction

      // Double-and-add product, 64 steps; operands stay below m < 2^63 so nothing overflows
      function bit [63:0] mul_mod(bit [63:0] a, bit [63:0] b, bit [63:0] m);
         bit [63:0] acc;
         acc = 0;
         a = reduce(a, m);
         b = reduce(b, m);
         for (int i = 0; i < 64; i++) begin
            if (b[i]) acc = reduce(acc + a, m);
            a = reduce(a + a, m);
         end
         return acc;
      endfunction

      function void take_root(logic [ROOT_W-1:0] root);
         bit [63:0]       m;
         bit [63:0]       neg;
         int unsigned     held;
         int unsigned     needed;
         rsp_payload_type item;
         m = {1'b0, modulus};
         needed = root_count;
         if (needed == 0) needed = 1;
         if (needed > MAX_ROOTS) needed = MAX_ROOTS;
         held = roots_held;
         if (held >= MAX_ROOTS) held = MAX_ROOTS - 1;
         neg = reduce(m - reduce(root, m), m);
         // fold from the top down so the update runs in place
         coeffs[held+1] = COEFF_W'(reduce({1'b0, coeffs[held]}, m));
         for (int p = held; p > 0; p--)
            coeffs[p] = COEFF_W'(reduce(mul_mod({1'b0, coeffs[p]}, neg, m)
                                        + reduce({1'b0, coeffs[p-1]}, m), m));
         coeffs[0] = COEFF_W'(mul_mod({1'b0, coeffs[0]}, neg, m));
         held++;
         roots_held = held;
         // polynomial complete: queue all coefficients, lowest degree first
         if (held >= needed) begin
            for (int p = 0; p <= held; p++) begin
               item.coefficient = coeffs[p];
               item.degree = DEG_W'(p);
               item.last = (p == held);
               pending_coeffs.push_back(item);
            end
            clear_poly();
         end
      endfunction

      function void check_coeff(rsp_payload_type got);
         rsp_payload_type want;
         if (pending_coeffs.size() == 0) begin
            $display("%0t: unexpected coefficient: actual coeff %0h degree %0d last %0b",
                     $time, got.coefficient, got.degree, got.last);
            failures++;
            return;
         end
         want = pending_coeffs.pop_front();
         if (got.coefficient !== want.coefficient) begin
            $display("%0t: coefficient mismatch at degree %0d: expected %0h, actual %0h",
                     $time, want.degree, want.coefficient, got.coefficient);
            failures++;
         end
         if (got.degree !== want.degree) begin
            $display("%0t: degree mismatch: expected %0d, actual %0d",
                     $time, want.degree, got.degree);
            failures++;
         end
         if (got.last !== want.last) begin
            $display("%0t: last flag mismatch at degree %0d: expected %0b, actual %0b",
                     $time, want.degree, want.last, got.last);
            failures++;
         end
      endfunction
   endclass

   coeff_tracker poly_coeffs = new();

   // Clock
   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Watchdog on the whole run
   initial begin
      cycle_count = 0;
      while (cycle_count < LIMIT_CYCLES) @(posedge clock) cycle_count++;
      $display("== FAIL ==");
      $finish;
   end

   // Drive the result ready with stall patterns picked at random, each held for a random span
   initial begin
      stall_mode_type mode;
      int unsigned    span;
      rsp_ch.ready = 1'b0;
      forever begin
         mode = stall_mode_type'($urandom_range(0, 3));
         span = $urandom_range(20, 120);
         for (int tick = 0; tick < span; tick++) begin
            @(negedge clock);
            case (mode)
               STALL_NONE:    rsp_ch.ready = 1'b1;
               STALL_COIN:    rsp_ch.ready = 1'($urandom_range(0, 1));
               STALL_QUARTER: rsp_ch.ready = (tick % 4 == 0);
               default:       rsp_ch.ready = (tick % 16) >= 12;
            endcase
         end
      end
   end

   // Check each result transaction
   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready) poly_coeffs.check_coeff(rsp_ch.payload);
   end

   // Offer one root and hold it until accepted; then keep the burst going or pause
   task automatic send_root(input logic [ROOT_W-1:0] root);
      int unsigned gap;
      req_ch.payload.root = root;
      req_ch.valid = 1'b1;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      poly_coeffs.take_root(root);
      @(negedge clock);
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         req_ch.valid = 1'b0;
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         repeat (gap) @(negedge clock);
         burst_left = $urandom_range(0, 24);
      end
   endtask

   task automatic write_csr(input csr_index_type idx, input logic [COEFF_W-1:0] value);
      csr_we = 1'b1;
      csr_index = idx;
      csr_wdata = value;
      @(posedge clock);
      poly_coeffs.write_reg(idx, value);
      @(negedge clock);
      csr_we = 1'b0;
   endtask

   // Drain outstanding coefficients, then let any fold still running finish
   task automatic wait_idle();
      req_ch.valid = 1'b0;
      while (poly_coeffs.pending_coeffs.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      @(negedge clock);
   endtask

   function automatic logic [COEFF_W-1:0] pick_modulus();
      logic [63:0] full;
      full = {$urandom, $urandom};
      case ($urandom_range(0, 9))
         0:       return COEFF_W'($urandom_range(2, 20));
         1, 2:    return COEFF_W'($urandom_range(2, 100000));
         3:       return COEFF_W'($urandom);
         4, 5, 6: return full[COEFF_W-1:0];
         7:       return {1'b1, full[COEFF_W-2:0]};
         8:       return MODULUS_MAX;
         default: return COEFF_W'($urandom_range(0, 3));
      endcase
   endfunction

   // Mostly small degrees keep the run short; zero and oversize counts appear now and then
   function automatic logic [RC_W-1:0] pick_root_count();
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4, 5: return RC_W'($urandom_range(1, 4));
         6, 7:             return RC_W'($urandom_range(5, 8));
         8:                return RC_W'($urandom_range(9, 15));
         default:          return '0;
      endcase
   endfunction

   function automatic logic [ROOT_W-1:0] pick_root(input logic [COEFF_W-1:0] m);
      logic [63:0] full;
      logic [63:0] wide_m;
      full = {$urandom, $urandom};
      wide_m = {1'b0, m};
      case ($urandom_range(0, 9))
         0, 1, 2, 3: return full;
         4:          return (wide_m == 0) ? full : full % wide_m;
         5:          return wide_m - 1;
         6:          return '0;
         7:          return wide_m * $urandom_range(1, 5);
         8:          return '1;
         default:    return wide_m + $urandom_range(0, 3);
      endcase
   endfunction

   // Main stimulus
   initial begin
      logic [ROOT_W-1:0] extremes [8] = '{
         64'hFFFF_FFFF_FFFF_FFFF, 64'h0, 64'h7FFF_FFFF_FFFF_FFFF, 64'h7FFF_FFFF_FFFF_FFFE,
         64'h8000_0000_0000_0000, 64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA, 64'h1
      };
      int unsigned sent;
      int unsigned needed;
      int unsigned total;

      reset = 1'b1;
      csr_we = 1'b0;
      csr_index = CSR_MODULUS;
      csr_wdata = '0;
      req_ch.valid = 1'b0;
      req_ch.payload = '0;
      burst_left = $urandom_range(0, 24);
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // reset settings: degree three over 65537
      send_root(64'h0);
      send_root(64'hFFFF_FFFF_FFFF_FFFF);
      send_root(64'd65537);

      // modulus zero: everything reduces to zero
      wait_idle();
      write_csr(CSR_MODULUS, '0);
      write_csr(CSR_ROOT_COUNT, COEFF_W'(2));
      send_root(64'h8000_0000_0000_0000);
      send_root(64'd12345);

      // modulus one with a root count of zero, which acts as one
      wait_idle();
      write_csr(CSR_MODULUS, COEFF_W'(1));
      write_csr(CSR_ROOT_COUNT, '0);
      send_root(64'd7);

      // largest modulus, oversize root count clamps to the full eight roots
      wait_idle();
      write_csr(CSR_MODULUS, MODULUS_MAX);
      write_csr(CSR_ROOT_COUNT, COEFF_W'(15));
      foreach (extremes[i]) send_root(extremes[i]);

      // lower the root count part way through a polynomial
      wait_idle();
      write_csr(CSR_MODULUS, COEFF_W'(97));
      write_csr(CSR_ROOT_COUNT, COEFF_W'(5));
      send_root(64'd96);
      send_root(64'd98);
      send_root(64'd1000);
      wait_idle();
      write_csr(CSR_ROOT_COUNT, COEFF_W'(2));
      send_root(64'd5);

      // change the modulus part way through a polynomial
      wait_idle();
      write_csr(CSR_MODULUS, COEFF_W'(1000003));
      write_csr(CSR_ROOT_COUNT, COEFF_W'(4));
      send_root(64'd999999);
      send_root(64'hDEAD_BEEF_0123_4567);
      wait_idle();
      write_csr(CSR_MODULUS, COEFF_W'(13));
      send_root(64'd12);
      send_root(64'd26);

      // random phases: whole polynomials, sometimes left part way for the next setting
      sent = 0;
      while (sent < RANDOM_ROOTS) begin
         wait_idle();
         if ($urandom_range(0, 3) != 0) write_csr(CSR_MODULUS, pick_modulus());
         if ($urandom_range(0, 3) != 0) write_csr(CSR_ROOT_COUNT, COEFF_W'(pick_root_count()));
         needed = poly_coeffs.root_count;
         if (needed == 0) needed = 1;
         if (needed > MAX_ROOTS) needed = MAX_ROOTS;
         total = needed * $urandom_range(1, 3);
         if ($urandom_range(0, 3) == 0) total += $urandom_range(1, needed);
         repeat (total) begin
            send_root(pick_root(poly_coeffs.modulus));
            sent++;
         end
      end

      // drain and settle, then report
      req_ch.valid = 1'b0;
      while (poly_coeffs.pending_coeffs.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (poly_coeffs.failures == 0 && poly_coeffs.pending_coeffs.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
